// File: rtl/core/dcrc_pkg.sv
`timescale 1ns / 1ps

package dcrc_pkg;

	// Default frame geometry
	localparam int FB_WIDTH_DEF    = 240;
	localparam int FB_HEIGHT_DEF   = 320;
	localparam int PIXEL_BYTES_DEF = 2;

	// Command opcodes
	localparam logic [7:0] CMD_NOP     = 8'h01;
	localparam logic [7:0] CMD_SLPIN   = 8'h10;
	localparam logic [7:0] CMD_SLPOUT  = 8'h11;
	localparam logic [7:0] CMD_NORON   = 8'h13;
	localparam logic [7:0] CMD_INVOFF  = 8'h20;
	localparam logic [7:0] CMD_INVON   = 8'h21;
	localparam logic [7:0] CMD_DISPOFF = 8'h28;
	localparam logic [7:0] CMD_DISPON  = 8'h29;
	localparam logic [7:0] CMD_CASET   = 8'h2a;
	localparam logic [7:0] CMD_RASET   = 8'h2b;
	localparam logic [7:0] CMD_RAMWR   = 8'h2c;
	localparam logic [7:0] CMD_MADCTL  = 8'h36;
	localparam logic [7:0] CMD_VSCSAD  = 8'h37;
	localparam logic [7:0] CMD_COLMOD  = 8'h3a;
	localparam logic [7:0] CMD_VENDOR  = 8'hc4;

	// Parameter checks for color mode and access control
	localparam logic [7:0] COLMOD_MASK = 8'h77;
	localparam logic [7:0] COLMOD_VAL  = 8'h55;
	localparam logic [7:0] MADCTL_MASK = 8'hfc;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_WINDOW  = 2'd1,
		ERR_FORMAT  = 2'd2,
		ERR_UNKNOWN = 2'd3
	} err_t;

	// Byte stream phase of the command decoder
	typedef enum logic [1:0] {
		MODE_CMD,
		MODE_PARAM,
		MODE_DATA
	} mode_t;

	// Per-transaction status carried down to the result register
	typedef struct packed {
		logic        sleeping;
		logic        disp_on;
		logic        inverted;
		logic [31:0] wr_count;
		err_t        err;
	} status_t;

	// Index width of a store of the given depth
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Width of the unreduced scanout address: scroll start plus read offset
	function automatic int off_w(input int row_bytes);
		return 16 + $clog2(row_bytes + 1) + 3;
	endfunction

endpackage

// File: rtl/core/dcrc_ifs.sv
`timescale 1ns / 1ps

interface dcrc_item_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  spi_byte;
	logic [17:0] read_offset;

	modport source(output valid, req_type, spi_byte, read_offset, input ready);
	modport sink(input valid, req_type, spi_byte, read_offset, output ready);
endinterface

interface dcrc_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        is_sleeping;
	logic        display_on;
	logic        color_inverted;
	logic [31:0] ram_write_count;
	logic [1:0]  error_code;

	modport source(output valid, read_data, is_sleeping, display_on, color_inverted,
		ram_write_count, error_code, input ready);
	modport sink(input valid, read_data, is_sleeping, display_on, color_inverted,
		ram_write_count, error_code, output ready);
endinterface

// File: rtl/core/dcrc_ctrl.sv
`timescale 1ns / 1ps

module dcrc_ctrl #(
	parameter int FB_WIDTH    = dcrc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = dcrc_pkg::FB_HEIGHT_DEF,
	parameter int PIXEL_BYTES = dcrc_pkg::PIXEL_BYTES_DEF,
	localparam int FRAME      = FB_WIDTH * FB_HEIGHT * PIXEL_BYTES,
	localparam int AW         = dcrc_pkg::addr_w(FRAME),
	localparam int XW         = dcrc_pkg::off_w(FB_WIDTH * PIXEL_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  logic                req_type,
	input  logic [7:0]          spi_byte,
	input  logic [17:0]         read_offset,
	output dcrc_pkg::status_t   stat,
	output logic                rd,
	output logic                wen,
	output logic [AW-1:0]       waddr,
	output logic [7:0]          wdata,
	output logic [XW-1:0]       rd_x
);

	localparam int RB = FB_WIDTH * PIXEL_BYTES;
	localparam int SW = 16 + $clog2(PIXEL_BYTES + 1);
	localparam int RW = $clog2(FB_HEIGHT + 1);

	dcrc_pkg::mode_t mode_q, mode_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [1:0]  pcnt_q, pcnt_d;
	logic [2:0]  pexp_q, pexp_d;
	logic [7:0]  pbyte_q [0:2];
	logic        sleep_q, sleep_d;
	logic        on_q, on_d;
	logic        inv_q, inv_d;
	logic [31:0] count_q, count_d;
	logic [15:0] xf_q, xf_d, xl_q, xl_d, yf_q, yf_d, yl_q, yl_d;
	logic [15:0] scroll_q, scroll_d;
	logic        bad_q, bad_d;
	logic [SW-1:0] stride_q, stride_d, dcol_q, dcol_d, dcol_inc;
	logic [15:0] dh_q, dh_d, drow_q, drow_d, drow_inc;
	dcrc_pkg::err_t err;

	logic [15:0] w16, h16;
	logic        win_bad, ram_len_nz, p_last, col_wrap, data_last;
	logic [RW-1:0] row;

	// Window size and sanity, as seen when a RAM write command arrives
	assign w16        = xl_q - xf_q + 16'd1;
	assign h16        = yl_q - yf_q + 16'd1;
	assign win_bad    = (xl_q < xf_q) || (yl_q < yf_q) ||
		(32'(xl_q) >= FB_WIDTH) || (32'(yl_q) >= FB_HEIGHT);
	assign ram_len_nz = (w16 != 16'd0) && (h16 != 16'd0);

	assign p_last    = ({1'b0, pcnt_q} + 3'd1) == pexp_q;
	assign dcol_inc  = dcol_q + SW'(1);
	assign drow_inc  = drow_q + 16'd1;
	assign col_wrap  = dcol_inc == stride_q;
	assign data_last = col_wrap && (drow_inc == dh_q);

	// Next phase of the byte stream
	always_comb begin
		mode_d = mode_q;
		if (!req_type) begin
			case (mode_q)
				dcrc_pkg::MODE_CMD: begin
					if (spi_byte inside {dcrc_pkg::CMD_COLMOD, dcrc_pkg::CMD_MADCTL,
						dcrc_pkg::CMD_VENDOR, dcrc_pkg::CMD_CASET, dcrc_pkg::CMD_RASET,
						dcrc_pkg::CMD_VSCSAD}) begin
						mode_d = dcrc_pkg::MODE_PARAM;
					end else if (spi_byte == dcrc_pkg::CMD_RAMWR && ram_len_nz) begin
						mode_d = dcrc_pkg::MODE_DATA;
					end
				end
				dcrc_pkg::MODE_PARAM: begin
					if (p_last)
						mode_d = dcrc_pkg::MODE_CMD;
				end
				dcrc_pkg::MODE_DATA: begin
					if (data_last)
						mode_d = dcrc_pkg::MODE_CMD;
				end
				default: mode_d = dcrc_pkg::MODE_CMD;
			endcase
		end
	end

	// Decode one byte: flags, window, counters, error and frame write
	always_comb begin
		cmd_d    = cmd_q;
		pcnt_d   = pcnt_q;
		pexp_d   = pexp_q;
		sleep_d  = sleep_q;
		on_d     = on_q;
		inv_d    = inv_q;
		count_d  = count_q;
		xf_d     = xf_q;
		xl_d     = xl_q;
		yf_d     = yf_q;
		yl_d     = yl_q;
		scroll_d = scroll_q;
		bad_d    = bad_q;
		stride_d = stride_q;
		dh_d     = dh_q;
		dcol_d   = dcol_q;
		drow_d   = drow_q;
		err      = dcrc_pkg::ERR_OK;
		wen      = 1'b0;
		if (!req_type) begin
			case (mode_q)
				dcrc_pkg::MODE_CMD: begin
					cmd_d  = spi_byte;
					pcnt_d = 2'd0;
					case (spi_byte)
						dcrc_pkg::CMD_NOP:     ;
						dcrc_pkg::CMD_NORON:   ;
						dcrc_pkg::CMD_SLPIN:   sleep_d = 1'b1;
						dcrc_pkg::CMD_SLPOUT:  sleep_d = 1'b0;
						dcrc_pkg::CMD_INVOFF:  inv_d   = 1'b0;
						dcrc_pkg::CMD_INVON:   inv_d   = 1'b1;
						dcrc_pkg::CMD_DISPOFF: on_d    = 1'b0;
						dcrc_pkg::CMD_DISPON:  on_d    = 1'b1;
						dcrc_pkg::CMD_COLMOD,
						dcrc_pkg::CMD_MADCTL,
						dcrc_pkg::CMD_VENDOR:  pexp_d  = 3'd1;
						dcrc_pkg::CMD_CASET,
						dcrc_pkg::CMD_RASET:   pexp_d  = 3'd4;
						dcrc_pkg::CMD_VSCSAD:  pexp_d  = 3'd2;
						dcrc_pkg::CMD_RAMWR: begin
							bad_d    = win_bad;
							err      = win_bad ? dcrc_pkg::ERR_WINDOW : dcrc_pkg::ERR_OK;
							count_d  = count_q + 32'd1;
							stride_d = SW'(w16 * PIXEL_BYTES);
							dh_d     = h16;
							dcol_d   = '0;
							drow_d   = '0;
						end
						default: err = dcrc_pkg::ERR_UNKNOWN;
					endcase
				end
				dcrc_pkg::MODE_PARAM: begin
					pcnt_d = pcnt_q + 2'd1;
					if (p_last) begin
						case (cmd_q)
							dcrc_pkg::CMD_COLMOD: begin
								if ((spi_byte & dcrc_pkg::COLMOD_MASK) != dcrc_pkg::COLMOD_VAL)
									err = dcrc_pkg::ERR_FORMAT;
							end
							dcrc_pkg::CMD_MADCTL: begin
								if ((spi_byte & dcrc_pkg::MADCTL_MASK) != 8'd0)
									err = dcrc_pkg::ERR_FORMAT;
							end
							dcrc_pkg::CMD_CASET: begin
								xf_d = {pbyte_q[0], pbyte_q[1]};
								xl_d = {pbyte_q[2], spi_byte};
							end
							dcrc_pkg::CMD_RASET: begin
								yf_d = {pbyte_q[0], pbyte_q[1]};
								yl_d = {pbyte_q[2], spi_byte};
							end
							dcrc_pkg::CMD_VSCSAD: scroll_d = {pbyte_q[0], spi_byte};
							default: ;
						endcase
					end
				end
				dcrc_pkg::MODE_DATA: begin
					// A bad window swallows its data without writing
					wen = !bad_q;
					if (col_wrap) begin
						dcol_d = '0;
						drow_d = drow_inc;
					end else begin
						dcol_d = dcol_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// Row-major frame address inside the window
	assign row   = RW'(yf_q) + RW'(drow_q);
	assign waddr = AW'((row * FB_WIDTH + xf_q) * PIXEL_BYTES + dcol_q);
	assign wdata = spi_byte;

	// Scanout address before wrap: scroll start plus offset
	assign rd   = req_type;
	assign rd_x = XW'(scroll_q * RB + read_offset);

	assign stat.sleeping = sleep_d;
	assign stat.disp_on  = on_d;
	assign stat.inverted = inv_d;
	assign stat.wr_count = count_d;
	assign stat.err      = err;

	// Commit state as the transaction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= dcrc_pkg::MODE_CMD;
			cmd_q    <= '0;
			pcnt_q   <= '0;
			pexp_q   <= '0;
			sleep_q  <= 1'b1;
			on_q     <= 1'b0;
			inv_q    <= 1'b0;
			count_q  <= '0;
			xf_q     <= '0;
			xl_q     <= '0;
			yf_q     <= '0;
			yl_q     <= '0;
			scroll_q <= '0;
			bad_q    <= 1'b0;
			stride_q <= '0;
			dh_q     <= '0;
			dcol_q   <= '0;
			drow_q   <= '0;
		end else if (commit) begin
			mode_q   <= mode_d;
			cmd_q    <= cmd_d;
			pcnt_q   <= pcnt_d;
			pexp_q   <= pexp_d;
			sleep_q  <= sleep_d;
			on_q     <= on_d;
			inv_q    <= inv_d;
			count_q  <= count_d;
			xf_q     <= xf_d;
			xl_q     <= xl_d;
			yf_q     <= yf_d;
			yl_q     <= yl_d;
			scroll_q <= scroll_d;
			bad_q    <= bad_d;
			stride_q <= stride_d;
			dh_q     <= dh_d;
			dcol_q   <= dcol_d;
			drow_q   <= drow_d;
		end
	end

	// Hold leading parameter bytes; the last one is used as it arrives
	always_ff @(posedge clk) begin
		if (commit && !req_type && mode_q == dcrc_pkg::MODE_PARAM && !p_last)
			pbyte_q[pcnt_q] <= spi_byte;
	end

endmodule

// File: rtl/core/dcrc_addr_pipe.sv
`timescale 1ns / 1ps

module dcrc_addr_pipe #(
	parameter int FB_WIDTH    = dcrc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = dcrc_pkg::FB_HEIGHT_DEF,
	parameter int PIXEL_BYTES = dcrc_pkg::PIXEL_BYTES_DEF,
	localparam int FRAME      = FB_WIDTH * FB_HEIGHT * PIXEL_BYTES,
	localparam int AW         = dcrc_pkg::addr_w(FRAME),
	localparam int XW         = dcrc_pkg::off_w(FB_WIDTH * PIXEL_BYTES)
) (
	input  logic          clk,
	input  logic          ld2,
	input  logic          ld3,
	input  logic          ld4,
	input  logic          rd,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [XW-1:0] rd_x,
	output logic          mem_rd,
	output logic          mem_wen,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata
);

	// Reciprocal of the frame size: quotient estimate is at most one low
	localparam longint MUL = (longint'(1) << XW) / FRAME;
	localparam int     MW  = $clog2(MUL + 1);

	logic          rd_s2, rd_s3, rd_s4;
	logic          wen_s2, wen_s3, wen_s4;
	logic [AW-1:0] waddr_s2, waddr_s3, waddr_s4;
	logic [7:0]    wdata_s2, wdata_s3, wdata_s4;
	logic [XW-1:0] x_s2, x_s3;
	logic [MW-1:0] q_s3;
	logic [AW:0]   r_s4;

	logic [XW+MW-1:0] prod;
	logic [XW-1:0]    qf;
	logic [AW:0]      r0;
	logic [AW-1:0]    rd_addr;

	// Estimate quotient of the scanout address by the frame size
	assign prod = (XW + MW)'(x_s2) * (XW + MW)'(MUL);

	// Remainder, below twice the frame size
	assign qf = XW'(q_s3 * FRAME);
	assign r0 = (AW + 1)'(x_s3 - qf);

	// Final wrap correction
	assign rd_addr = (32'(r_s4) >= FRAME) ? AW'(32'(r_s4) - FRAME) : AW'(r_s4);

	always_ff @(posedge clk) begin
		if (ld2) begin
			rd_s2    <= rd;
			wen_s2   <= wen;
			waddr_s2 <= waddr;
			wdata_s2 <= wdata;
			x_s2     <= rd_x;
		end
		if (ld3) begin
			rd_s3    <= rd_s2;
			wen_s3   <= wen_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
			x_s3     <= x_s2;
			q_s3     <= prod[XW+MW-1:XW];
		end
		if (ld4) begin
			rd_s4    <= rd_s3;
			wen_s4   <= wen_s3;
			waddr_s4 <= waddr_s3;
			wdata_s4 <= wdata_s3;
			r_s4     <= r0;
		end
	end

	assign mem_rd    = rd_s4;
	assign mem_wen   = wen_s4;
	assign mem_addr  = rd_s4 ? rd_addr : waddr_s4;
	assign mem_wdata = wdata_s4;

endmodule

// File: rtl/core/dcrc_frame_mem.sv
`timescale 1ns / 1ps

module dcrc_frame_mem #(
	parameter int DEPTH = dcrc_pkg::FB_WIDTH_DEF * dcrc_pkg::FB_HEIGHT_DEF *
		dcrc_pkg::PIXEL_BYTES_DEF,
	localparam int AW   = dcrc_pkg::addr_w(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          rd,
	input  logic          wen,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata,
	output logic          busy
);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          busy_q;
	logic [7:0]    rdata_q;

	// Sweep the memory to zero after reset, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == AW'(DEPTH - 1))
				busy_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// One port: clear, pixel write or scanout read
	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_idx_q] <= 8'd0;
		else if (en && wen)
			mem[addr] <= wdata;
		if (en && rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: rtl/core/display_cmd_ram_controller_top.sv
`timescale 1ns / 1ps

// Serial display command controller with an on-chip frame memory. Each transaction on
// item is either one SPI byte (command, parameter or pixel data) or one scanout read of
// a frame byte; every transaction produces exactly one result on result, in order. One
// transaction is accepted per clock while item.ready is high. Its result is registered in
// turn by an input register feeding the command decoder, three stages that wrap the
// scrolled scanout address around the frame, and the single frame-memory port, which
// every transaction uses at most once and which loads the result register. After reset
// the memory is swept to zero, one byte per cycle, over all
// FB_WIDTH*FB_HEIGHT*PIXEL_BYTES bytes (153600 at the defaults); item.ready stays low
// during the sweep. Backpressure on result stalls only as far back as the first empty
// stage.
module display_cmd_ram_controller_top #(
	parameter int FB_WIDTH    = dcrc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = dcrc_pkg::FB_HEIGHT_DEF,
	parameter int PIXEL_BYTES = dcrc_pkg::PIXEL_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dcrc_item_if.sink             item,
	dcrc_result_if.source         result
);

	localparam int FRAME = FB_WIDTH * FB_HEIGHT * PIXEL_BYTES;
	localparam int AW    = dcrc_pkg::addr_w(FRAME);
	localparam int XW    = dcrc_pkg::off_w(FB_WIDTH * PIXEL_BYTES);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic commit, fire4, busy;

	logic        req_s1;
	logic [7:0]  byte_s1;
	logic [17:0] off_s1;

	dcrc_pkg::status_t stat, st_s2, st_s3, st_s4, st_s5;
	logic          rd, wen;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [XW-1:0] rd_x;
	logic          mem_rd, mem_wen;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          rd_s5;

	// Elastic pipeline: a stage loads when empty or when its content moves on
	assign rdy5   = !v_s5 || result.ready;
	assign rdy4   = !v_s4 || rdy5;
	assign rdy3   = !v_s3 || rdy4;
	assign rdy2   = !v_s2 || rdy3;
	assign rdy1   = !v_s1 || rdy2;
	assign commit = v_s1 && rdy2;
	assign fire4  = v_s4 && rdy5;

	assign item.ready = rdy1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item.valid && item.ready;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Capture the transaction and carry its status to the result register
	always_ff @(posedge clk) begin
		if (rdy1) begin
			req_s1  <= item.req_type;
			byte_s1 <= item.spi_byte;
			off_s1  <= item.read_offset;
		end
		if (rdy2) st_s2 <= stat;
		if (rdy3) st_s3 <= st_s2;
		if (rdy4) st_s4 <= st_s3;
		if (rdy5) begin
			st_s5 <= st_s4;
			rd_s5 <= mem_rd;
		end
	end

	dcrc_ctrl #(
		.FB_WIDTH    (FB_WIDTH),
		.FB_HEIGHT   (FB_HEIGHT),
		.PIXEL_BYTES (PIXEL_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (commit),
		.req_type    (req_s1),
		.spi_byte    (byte_s1),
		.read_offset (off_s1),
		.stat        (stat),
		.rd          (rd),
		.wen         (wen),
		.waddr       (waddr),
		.wdata       (wdata),
		.rd_x        (rd_x)
	);

	dcrc_addr_pipe #(
		.FB_WIDTH    (FB_WIDTH),
		.FB_HEIGHT   (FB_HEIGHT),
		.PIXEL_BYTES (PIXEL_BYTES)
	) u_addr_pipe (
		.clk       (clk),
		.ld2       (rdy2),
		.ld3       (rdy3),
		.ld4       (rdy4),
		.rd        (rd),
		.wen       (wen),
		.waddr     (waddr),
		.wdata     (wdata),
		.rd_x      (rd_x),
		.mem_rd    (mem_rd),
		.mem_wen   (mem_wen),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	dcrc_frame_mem #(
		.DEPTH (FRAME)
	) u_frame_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire4),
		.rd     (mem_rd),
		.wen    (mem_wen),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (busy)
	);

	// Result register outputs
	assign result.valid           = v_s5;
	assign result.read_data       = rd_s5 ? mem_rdata : 8'd0;
	assign result.is_sleeping     = st_s5.sleeping;
	assign result.display_on      = st_s5.disp_on;
	assign result.color_inverted  = st_s5.inverted;
	assign result.ram_write_count = st_s5.wr_count;
	assign result.error_code      = st_s5.err;

endmodule

// File: rtl/core/dcrc_checker.sv
`timescale 1ns / 1ps

module dcrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  read_data,
	input logic        is_sleeping,
	input logic        display_on,
	input logic        color_inverted,
	input logic [31:0] ram_write_count,
	input logic [1:0]  error_code
);

	// A stalled result holds
	ast_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_data) &&
		$stable(is_sleeping) && $stable(display_on) && $stable(color_inverted) &&
		$stable(ram_write_count) && $stable(error_code))
		else $error("result changed while stalled");

	// No transaction is taken right after reset: the frame clear runs first
	ast_clear_block: assert property (@(posedge clk)
		!arst_n |=> !item_ready)
		else $error("item accepted before frame clear");

	// Frame data only comes back on reads, which never report an error
	ast_read_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && read_data != 8'd0 |-> error_code == dcrc_pkg::ERR_OK)
		else $error("read result carries an error code");

	// Back-to-back results advance the write count by at most one
	ast_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready ##1 res_valid |->
		(ram_write_count == $past(ram_write_count) ||
		ram_write_count == $past(ram_write_count) + 32'd1))
		else $error("write count jumped");

endmodule

bind display_cmd_ram_controller_top dcrc_checker u_dcrc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_ready      (item.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.read_data       (result.read_data),
	.is_sleeping     (result.is_sleeping),
	.display_on      (result.display_on),
	.color_inverted  (result.color_inverted),
	.ram_write_count (result.ram_write_count),
	.error_code      (result.error_code)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dcrc_pkg::*;

	localparam int FBW         = FB_WIDTH_DEF;
	localparam int FBH         = FB_HEIGHT_DEF;
	localparam int PIX         = PIXEL_BYTES_DEF;
	localparam int ROW_BYTES   = FBW * PIX;
	localparam int FRAME_BYTES = FBW * FBH * PIX;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  spi_byte;
		logic [17:0] read_offset;
	} dcs_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        sleeping;
		logic        disp_on;
		logic        inverted;
		logic [31:0] wr_count;
		err_t        err;
	} dcs_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	dcrc_item_if   item_ch();
	dcrc_result_if result_ch();

	display_cmd_ram_controller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Controller mirror: flags, parser, window and frame contents
	bit          sleep_f = 1'b1;
	bit          on_f;
	bit          invert_f;
	bit          normal_f;
	bit [31:0]   wr_total;
	bit [7:0]    cur_cmd;
	bit [63:0]   need_cnt;
	bit [63:0]   got_cnt;
	bit [7:0]    param_q [4];
	bit [15:0]   win_x0, win_x1, win_y0, win_y1;
	bit [15:0]   scroll_row;
	bit [9:0]    col_byte;
	bit [8:0]    row_idx;
	bit          win_bad;
	bit [7:0]    fb_mem [FRAME_BYTES];

	dcs_item_t   pending [$];
	dcs_status_t status_q [$];

	int fail_cnt;
	int sent_cnt;
	int checked_cnt;
	int read_cnt;
	int flagged_cnt;
	int cycle_cnt;
	logic [31:0] last_wr_count;

	// Stimulus-side view of the window and scroll, used to keep pixel bursts short
	logic [15:0] gx0, gx1, gy0, gy1, gscroll;
	int last_base;
	int last_len = 2;

	// Advance the mirror by one transaction and return the status it produces
	function automatic dcs_status_t dcs_apply(input dcs_item_t it);
		dcs_status_t r;
		logic [15:0] w, h;
		logic [31:0] stride, addr;
		logic [63:0] scan;
		r.read_data = 8'h00;
		r.err = ERR_OK;
		if (it.req_type) begin
			scan = 64'(scroll_row) * 64'(ROW_BYTES) + 64'(it.read_offset);
			r.read_data = fb_mem[scan % 64'(FRAME_BYTES)];
		end else if (got_cnt < need_cnt) begin
			if (cur_cmd == CMD_RAMWR) begin
				// place the pixel byte unless the window was rejected
				if (!win_bad) begin
					stride = (32'(win_x1) - 32'(win_x0) + 32'd1) * 32'(PIX);
					addr = ((32'(win_y0) + 32'(row_idx)) * 32'(FBW) + 32'(win_x0)) * 32'(PIX)
						+ 32'(col_byte);
					if (addr < 32'(FRAME_BYTES))
						fb_mem[addr] = it.spi_byte;
					if (32'(col_byte) + 32'd1 >= stride) begin
						col_byte = '0;
						row_idx = row_idx + 9'd1;
					end else begin
						col_byte = col_byte + 10'd1;
					end
				end
				got_cnt = got_cnt + 64'd1;
			end else begin
				param_q[got_cnt[1:0]] = it.spi_byte;
				got_cnt = got_cnt + 64'd1;
				if (got_cnt == need_cnt) begin
					case (cur_cmd)
						CMD_COLMOD: begin
							if ((param_q[0] & COLMOD_MASK) != COLMOD_VAL)
								r.err = ERR_FORMAT;
						end
						CMD_MADCTL: begin
							if ((param_q[0] & MADCTL_MASK) != 8'h00)
								r.err = ERR_FORMAT;
						end
						CMD_CASET: begin
							win_x0 = {param_q[0], param_q[1]};
							win_x1 = {param_q[2], param_q[3]};
						end
						CMD_RASET: begin
							win_y0 = {param_q[0], param_q[1]};
							win_y1 = {param_q[2], param_q[3]};
						end
						CMD_VSCSAD: scroll_row = {param_q[0], param_q[1]};
						default: ;
					endcase
				end
			end
		end else begin
			// command byte
			cur_cmd = it.spi_byte;
			got_cnt = '0;
			need_cnt = '0;
			case (it.spi_byte)
				CMD_NOP: ;
				CMD_SLPIN: sleep_f = 1'b1;
				CMD_SLPOUT: sleep_f = 1'b0;
				CMD_NORON: normal_f = 1'b1;
				CMD_INVOFF: invert_f = 1'b0;
				CMD_INVON: invert_f = 1'b1;
				CMD_DISPOFF: on_f = 1'b0;
				CMD_DISPON: on_f = 1'b1;
				CMD_COLMOD, CMD_MADCTL, CMD_VENDOR: need_cnt = 64'd1;
				CMD_CASET, CMD_RASET: need_cnt = 64'd4;
				CMD_VSCSAD: need_cnt = 64'd2;
				CMD_RAMWR: begin
					w = win_x1 - win_x0 + 16'd1;
					h = win_y1 - win_y0 + 16'd1;
					win_bad = (win_x1 < win_x0) || (win_y1 < win_y0) ||
						(32'(win_x1) >= 32'(FBW)) || (32'(win_y1) >= 32'(FBH));
					if (win_bad)
						r.err = ERR_WINDOW;
					need_cnt = 64'(w) * 64'(h) * 64'(PIX);
					col_byte = '0;
					row_idx = '0;
					wr_total = wr_total + 32'd1;
				end
				default: r.err = ERR_UNKNOWN;
			endcase
		end
		r.sleeping = sleep_f;
		r.disp_on = on_f;
		r.inverted = invert_f;
		r.wr_count = wr_total;
		return r;
	endfunction

	task automatic push_spi(input logic [7:0] b);
		dcs_item_t t;
		t.req_type = 1'b0;
		t.spi_byte = b;
		t.read_offset = 18'($urandom);
		pending.push_back(t);
	endtask

	task automatic push_read(input logic [17:0] off);
		dcs_item_t t;
		t.req_type = 1'b1;
		t.spi_byte = 8'($urandom);
		t.read_offset = off;
		pending.push_back(t);
	endtask

	task automatic send_window(input logic [7:0] cmd, input logic [15:0] first,
		input logic [15:0] last);
		push_spi(cmd);
		push_spi(first[15:8]);
		push_spi(first[7:0]);
		push_spi(last[15:8]);
		push_spi(last[7:0]);
		if (cmd == CMD_CASET) begin
			gx0 = first;
			gx1 = last;
		end else begin
			gy0 = first;
			gy1 = last;
		end
	endtask

	task automatic send_scroll(input logic [15:0] v);
		push_spi(CMD_VSCSAD);
		push_spi(v[15:8]);
		push_spi(v[7:0]);
		gscroll = v;
	endtask

	// Small in-frame window, now and then pinned to a frame edge
	task automatic send_good_window();
		int wpx, hpx, x0, y0;
		wpx = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 16 : 6);
		hpx = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 8 : 3);
		case ($urandom_range(0, 3))
			0: x0 = 0;
			1: x0 = FBW - wpx;
			default: x0 = $urandom_range(0, FBW - wpx);
		endcase
		case ($urandom_range(0, 3))
			0: y0 = 0;
			1: y0 = FBH - hpx;
			default: y0 = $urandom_range(0, FBH - hpx);
		endcase
		send_window(CMD_CASET, 16'(x0), 16'(x0 + wpx - 1));
		send_window(CMD_RASET, 16'(y0), 16'(y0 + hpx - 1));
	endtask

	function automatic logic [63:0] burst_len();
		return 64'(16'(gx1 - gx0 + 16'd1)) * 64'(16'(gy1 - gy0 + 16'd1)) * 64'(PIX);
	endfunction

	// Scanout offset that lands near the last written window under the current scroll
	function automatic logic [17:0] aimed_offset();
		int a, sh, off;
		a = (last_base + $urandom_range(0, last_len + 2 * ROW_BYTES)) % FRAME_BYTES;
		sh = (int'(gscroll) * ROW_BYTES) % FRAME_BYTES;
		off = (a - sh + FRAME_BYTES) % FRAME_BYTES;
		if (off + FRAME_BYTES < 262144 && $urandom_range(0, 3) == 0)
			off = off + FRAME_BYTES;
		return 18'(off);
	endfunction

	// Write-to-RAM with its full pixel burst, reads mixed in
	task automatic send_ramwr();
		logic [63:0] n;
		bit good;
		n = burst_len();
		if (n > 64'd512) begin
			send_good_window();
			n = burst_len();
		end
		good = (gx1 >= gx0) && (gy1 >= gy0) && (32'(gx1) < 32'(FBW)) && (32'(gy1) < 32'(FBH));
		push_spi(CMD_RAMWR);
		for (int k = 0; k < int'(n); k++) begin
			if ($urandom_range(0, 9) == 0)
				push_read(aimed_offset());
			push_spi(8'($urandom));
		end
		if (good && n != 0) begin
			last_base = (int'(gy0) * FBW + int'(gx0)) * PIX;
			last_len = int'(n);
		end
	endtask

	// Offer the queued transactions, with random gaps and gap-free stretches
	bit in_burst;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin : driver
		dcs_item_t acc, nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.req_type <= 1'b0;
			item_ch.spi_byte <= 8'h00;
			item_ch.read_offset <= 18'd0;
			gap_left <= 0;
			sent_cnt <= 0;
			in_burst <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				acc.req_type = item_ch.req_type;
				acc.spi_byte = item_ch.spi_byte;
				acc.read_offset = item_ch.read_offset;
				status_q.push_back(dcs_apply(acc));
				sent_cnt <= sent_cnt + 1;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left != 0) begin
					item_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.req_type <= nxt.req_type;
					item_ch.spi_byte <= nxt.spi_byte;
					item_ch.read_offset <= nxt.read_offset;
					gap_left <= in_burst ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 39) == 0)
						in_burst <= !in_burst;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off so the pipeline fills and input ready drops
	bit long_hold;
	int hold_left;
	int holds_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (long_hold) begin
			if (hold_left == 0)
				long_hold <= 1'b0;
			else
				hold_left <= hold_left - 1;
		end else if (holds_done < 2 && sent_cnt >= 600 * (holds_done + 1)) begin
			long_hold <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Take results with random stalls and compare against the oldest expected status
	bit out_burst;
	int stall_left;

	always @(posedge clk or negedge arst_n) begin : monitor
		dcs_status_t want;
		int s;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left <= 0;
			out_burst <= 1'b0;
		end else begin
			s = stall_left;
			if (result_ch.valid && result_ch.ready) begin
				if (status_q.size() == 0) begin
					$error("result transaction with no expected status pending");
					fail_cnt++;
				end else begin
					want = status_q.pop_front();
					if (result_ch.read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data,
							result_ch.read_data);
						fail_cnt++;
					end
					if (result_ch.is_sleeping !== want.sleeping) begin
						$error("is_sleeping: expected %0b, got %0b", want.sleeping,
							result_ch.is_sleeping);
						fail_cnt++;
					end
					if (result_ch.display_on !== want.disp_on) begin
						$error("display_on: expected %0b, got %0b", want.disp_on,
							result_ch.display_on);
						fail_cnt++;
					end
					if (result_ch.color_inverted !== want.inverted) begin
						$error("color_inverted: expected %0b, got %0b", want.inverted,
							result_ch.color_inverted);
						fail_cnt++;
					end
					if (result_ch.ram_write_count !== want.wr_count) begin
						$error("ram_write_count: expected %0d, got %0d", want.wr_count,
							result_ch.ram_write_count);
						fail_cnt++;
					end
					if (result_ch.error_code !== want.err) begin
						$error("error_code: expected %0d, got %0d", want.err,
							result_ch.error_code);
						fail_cnt++;
					end
					checked_cnt++;
					if (want.err != ERR_OK)
						flagged_cnt++;
					last_wr_count = want.wr_count;
				end
				s = out_burst ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 39) == 0)
					out_burst <= !out_burst;
			end
			if (s != 0) begin
				result_ch.ready <= 1'b0;
				stall_left <= s - 1;
			end else begin
				result_ch.ready <= !long_hold;
				stall_left <= 0;
			end
		end
	end

	// Count scanout reads as they are accepted
	always @(posedge clk) begin
		if (item_ch.valid && item_ch.ready && item_ch.req_type)
			read_cnt <= read_cnt + 1;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("display_cmd_ram_controller_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int pick;
		bit known;
		logic [7:0] b;
		logic [15:0] v0, v1;
		int k;

		arst_n <= 1'b0;
		gx0 = '0;
		gx1 = '0;
		gy0 = '0;
		gy1 = '0;
		gscroll = '0;

		// Directed: reset state, every simple command, parameter checks, extremes
		push_read(18'd0);
		push_spi(CMD_NOP);
		push_spi(CMD_SLPOUT);
		push_spi(CMD_NORON);
		push_spi(CMD_INVON);
		push_spi(CMD_DISPON);
		push_spi(CMD_INVOFF);
		push_spi(CMD_DISPOFF);
		push_spi(CMD_SLPIN);
		push_spi(CMD_COLMOD);
		push_spi(COLMOD_VAL);
		push_spi(CMD_COLMOD);
		push_spi(8'hff);
		push_spi(CMD_MADCTL);
		push_spi(MADCTL_MASK);
		push_spi(8'h00);
		push_spi(CMD_VENDOR);
		push_spi(8'h00);
		send_scroll(16'hffff);
		push_read(18'h3ffff);
		send_ramwr();
		push_read(aimed_offset());

		// Random: mostly well-formed command sequences, some noise and bad windows
		while (pending.size() < RANDOM_ITEMS + 26) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				case ($urandom_range(0, 7))
					0: b = CMD_NOP;
					1: b = CMD_SLPIN;
					2: b = CMD_SLPOUT;
					3: b = CMD_NORON;
					4: b = CMD_INVOFF;
					5: b = CMD_INVON;
					6: b = CMD_DISPOFF;
					default: b = CMD_DISPON;
				endcase
				push_spi(b);
			end else if (pick < 16) begin
				b = $urandom_range(0, 1) ? (COLMOD_VAL | (8'($urandom) & ~COLMOD_MASK))
					: 8'($urandom);
				push_spi(CMD_COLMOD);
				push_spi(b);
			end else if (pick < 22) begin
				b = $urandom_range(0, 1) ? (8'($urandom) & ~MADCTL_MASK) : 8'($urandom);
				push_spi(CMD_MADCTL);
				push_spi(b);
			end else if (pick < 26) begin
				push_spi(CMD_VENDOR);
				push_spi(8'($urandom));
			end else if (pick < 32) begin
				case ($urandom_range(0, 3))
					0: v0 = 16'h0000;
					1: v0 = 16'hffff;
					2: v0 = 16'($urandom_range(0, FBH - 1));
					default: v0 = 16'($urandom);
				endcase
				send_scroll(v0);
			end else if (pick < 40) begin
				send_good_window();
			end else if (pick < 47) begin
				// rejected windows: off-frame, reversed, far out in 16-bit space
				case ($urandom_range(0, 4))
					0: begin
						send_good_window();
						k = $urandom_range(FBW - 8, FBW + 60);
						v1 = 16'(((k < FBW) ? FBW : k) + $urandom_range(0, 3));
						send_window(CMD_CASET, 16'(k), v1);
					end
					1: begin
						send_good_window();
						k = $urandom_range(1, 300);
						send_window(CMD_CASET, 16'(k), 16'(k - 1));
					end
					2: begin
						send_window(CMD_CASET, 16'($urandom), 16'($urandom));
						k = $urandom_range(1, 400);
						send_window(CMD_RASET, 16'(k), 16'(k - 1));
					end
					3: begin
						send_good_window();
						k = $urandom_range(FBH - 4, FBH + 10);
						v1 = 16'(((k < FBH) ? FBH : k) + $urandom_range(0, 2));
						send_window(CMD_RASET, 16'(k), v1);
					end
					default: begin
						send_good_window();
						send_window(CMD_CASET, 16'hfffe, 16'hffff);
					end
				endcase
				send_ramwr();
			end else if (pick < 67) begin
				send_ramwr();
			end else if (pick < 82) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: push_read(aimed_offset());
					5, 6, 7: push_read(18'($urandom_range(0, FRAME_BYTES - 1)));
					default: push_read(18'($urandom));
				endcase
			end else if (pick < 88) begin
				known = 1'b1;
				while (known) begin
					b = 8'($urandom);
					case (b)
						CMD_NOP, CMD_SLPIN, CMD_SLPOUT, CMD_NORON, CMD_INVOFF, CMD_INVON,
						CMD_DISPOFF, CMD_DISPON, CMD_CASET, CMD_RASET, CMD_RAMWR,
						CMD_MADCTL, CMD_VSCSAD, CMD_COLMOD, CMD_VENDOR: known = 1'b1;
						default: known = 1'b0;
					endcase
				end
				push_spi(b);
			end else begin
				// noise byte: random opcode, framed so the parser state stays known
				b = 8'($urandom);
				case (b)
					CMD_CASET, CMD_RASET: send_window(b, 16'($urandom), 16'($urandom));
					CMD_COLMOD, CMD_MADCTL, CMD_VENDOR: begin
						push_spi(b);
						push_spi(8'($urandom));
					end
					CMD_VSCSAD: send_scroll(16'($urandom));
					CMD_RAMWR: send_ramwr();
					default: push_spi(b);
				endcase
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all offered, all results back, then an idle stretch before the summary
		while (pending.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d results: %0d scanout reads, %0d flagged errors", checked_cnt,
			read_cnt, flagged_cnt);
		$display("%0d write-to-RAM commands over good, reversed and off-frame windows",
			last_wr_count);
		if (fail_cnt == 0) begin
			$display("display_cmd_ram_controller_top regression: pass");
		end else begin
			$display("display_cmd_ram_controller_top regression: fail");
		end
		$finish;
	end

endmodule
